[rtl/vec3_normalize_top_defines.svh]
// assertion macros for the vector normalize block
// no dependencies; taken in by the top level only
`ifndef VEC3_NORMALIZE_TOP_DEFINES_SVH
`define VEC3_NORMALIZE_TOP_DEFINES_SVH

// implication checked on every edge outside reset
`define VN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// implication with the consequent checked in the next cycle
`define VN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/vn_pkg.sv]
// shared widths and stage payload types for the vector normalize block
// no dependencies
package vn_pkg;

    localparam int IN_W        = 16;
    localparam int FRAC_W      = 14;
    localparam int SUM_W       = 2 * IN_W;
    localparam int ROOT_W      = IN_W;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int QW          = FRAC_W + 1;
    localparam int DIV_STAGES  = QW;
    localparam int DIVD_W      = IN_W + FRAC_W;
    localparam int OUT_W       = 16;

    // component magnitudes and signs riding alongside the root
    typedef struct packed {
        logic [IN_W-1:0] ax;
        logic [IN_W-1:0] ay;
        logic [IN_W-1:0] az;
        logic            nx;
        logic            ny;
        logic            nz;
    } vn_tag_t;

    // what rides alongside the divider lanes
    typedef struct packed {
        logic [ROOT_W-1:0] len;
        logic              zero;
        logic              nx;
        logic              ny;
        logic              nz;
    } vn_side_t;

endpackage

[rtl/vn_sqrt.sv]
// pipelined integer square root, one root bit per stage
// depends on vn_pkg
module vn_sqrt (
    input  logic                              aclk,
    input  logic [vn_pkg::SQRT_STAGES-1:0]    ld,
    input  logic [vn_pkg::SUM_W-1:0]          sum_in,
    input  vn_pkg::vn_tag_t                   tag_in,
    output logic [vn_pkg::ROOT_W-1:0]         root_out,
    output vn_pkg::vn_tag_t                   tag_out
);
    import vn_pkg::*;

    logic [SUM_W-1:0] n_reg   [SQRT_STAGES];
    logic [SUM_W-1:0] r_reg   [SQRT_STAGES];
    vn_tag_t          tag_reg [SQRT_STAGES];

    genvar i;
    generate
        for (i = 0; i < SQRT_STAGES; i++) begin : g_stage
            logic [SUM_W-1:0] n_prev, r_prev, bitv, n_next, r_next;
            logic [SUM_W:0]   trial;
            vn_tag_t          tag_prev;

            if (i == 0) begin : g_first
                assign n_prev   = sum_in;
                assign r_prev   = '0;
                assign tag_prev = tag_in;
            end else begin : g_rest
                assign n_prev   = n_reg[i-1];
                assign r_prev   = r_reg[i-1];
                assign tag_prev = tag_reg[i-1];
            end

            assign bitv = SUM_W'(1) << (SUM_W - 2 - 2 * i);

            always_comb begin
                trial = {1'b0, r_prev} + {1'b0, bitv};
                if ({1'b0, n_prev} >= trial) begin
                    n_next = n_prev - trial[SUM_W-1:0];
                    r_next = (r_prev >> 1) + bitv;
                end else begin
                    n_next = n_prev;
                    r_next = r_prev >> 1;
                end
            end

            always_ff @(posedge aclk) begin
                if (ld[i]) begin
                    n_reg[i]   <= n_next;
                    r_reg[i]   <= r_next;
                    tag_reg[i] <= tag_prev;
                end
            end
        end
    endgenerate

    assign root_out = r_reg[SQRT_STAGES-1][ROOT_W-1:0];
    assign tag_out  = tag_reg[SQRT_STAGES-1];

endmodule

[rtl/vn_div_lane.sv]
// one divider lane: rounded quotient of a component over the length,
// one quotient bit per stage; depends on vn_pkg
module vn_div_lane (
    input  logic                            aclk,
    input  logic [vn_pkg::DIV_STAGES-1:0]   ld,
    input  logic [vn_pkg::IN_W-1:0]         mag_in,
    input  logic [vn_pkg::ROOT_W-1:0]       len_in,
    output logic [vn_pkg::QW-1:0]           quo_out
);
    import vn_pkg::*;

    logic [DIVD_W-1:0] rem_reg [DIV_STAGES];
    logic [ROOT_W-1:0] len_reg [DIV_STAGES];
    logic [QW-1:0]     quo_reg [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_stage
            logic [DIVD_W-1:0] rem_prev, rem_next, t;
            logic [ROOT_W-1:0] len_prev;
            logic [QW-1:0]     quo_prev, quo_next;

            if (k == 0) begin : g_first
                // dividend with half the divisor added for round to nearest
                assign rem_prev = {mag_in, {FRAC_W{1'b0}}}
                                + DIVD_W'(len_in >> 1);
                assign len_prev = len_in;
                assign quo_prev = '0;
            end else begin : g_rest
                assign rem_prev = rem_reg[k-1];
                assign len_prev = len_reg[k-1];
                assign quo_prev = quo_reg[k-1];
            end

            assign t = DIVD_W'(len_prev) << (QW - 1 - k);

            always_comb begin
                quo_next = quo_prev;
                if (rem_prev >= t) begin
                    rem_next = rem_prev - t;
                    quo_next[QW-1-k] = 1'b1;
                end else begin
                    rem_next = rem_prev;
                end
            end

            always_ff @(posedge aclk) begin
                if (ld[k]) begin
                    rem_reg[k] <= rem_next;
                    len_reg[k] <= len_prev;
                    quo_reg[k] <= quo_next;
                end
            end
        end
    endgenerate

    assign quo_out = quo_reg[DIV_STAGES-1];

endmodule

[rtl/vec3_normalize_top.sv]
// top level of the vector normalize block: input stage, squares, sqrt,
// three divider lanes and the merging output stage; depends on vn_pkg,
// vn_sqrt, vn_div_lane and vec3_normalize_top_defines.svh
//
// Takes one vector per cycle while the output side is not stalled and gives
// its length and unit vector. The pipeline is 35 stages deep: input abs,
// squares, sum, 16 square-root stages (one root bit each), 15 divider
// stages in three parallel lanes (one quotient bit each) and the output
// register. Each stage moves on when it is empty or the stage after it
// moves on, so bubbles close up and new items are taken while a result
// waits. A zero vector gives zero units, zero length and the zero_length
// flag on m_tuser.
`include "vec3_normalize_top_defines.svh"

module vec3_normalize_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // in_x, in_y, in_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // unit_x, unit_y, unit_z, magnitude
    output logic        m_tuser    // zero_length
);
    import vn_pkg::*;

    localparam int P_RT  = 3;
    localparam int P_DV  = P_RT + SQRT_STAGES;
    localparam int P_OUT = P_DV + DIV_STAGES;
    localparam int NST   = P_OUT + 1;

    logic [NST-1:0] v_reg, v_next, ld;

    always_comb begin
        ld[NST-1] = !v_reg[NST-1] || m_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
        v_next[0] = ld[0] ? s_tvalid : v_reg[0];
        for (int k = 1; k < NST; k++) begin
            v_next[k] = ld[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_tready = ld[0];

    // stage 0: sign and magnitude of each component
    logic [IN_W-1:0] xin, yin, zin;
    vn_tag_t         tag0_reg, tag1_reg, tag2_reg;
    logic [SUM_W-2:0] sqx_reg, sqy_reg, sqz_reg;
    logic [SUM_W-1:0] sum_reg;

    assign xin = s_tdata[IN_W-1:0];
    assign yin = s_tdata[2*IN_W-1:IN_W];
    assign zin = s_tdata[3*IN_W-1:2*IN_W];

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            tag0_reg.nx <= xin[IN_W-1];
            tag0_reg.ny <= yin[IN_W-1];
            tag0_reg.nz <= zin[IN_W-1];
            tag0_reg.ax <= xin[IN_W-1] ? (~xin + 1'b1) : xin;
            tag0_reg.ay <= yin[IN_W-1] ? (~yin + 1'b1) : yin;
            tag0_reg.az <= zin[IN_W-1] ? (~zin + 1'b1) : zin;
        end
        if (ld[1]) begin
            sqx_reg  <= (SUM_W-1)'(tag0_reg.ax * tag0_reg.ax);
            sqy_reg  <= (SUM_W-1)'(tag0_reg.ay * tag0_reg.ay);
            sqz_reg  <= (SUM_W-1)'(tag0_reg.az * tag0_reg.az);
            tag1_reg <= tag0_reg;
        end
        if (ld[2]) begin
            sum_reg  <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
            tag2_reg <= tag1_reg;
        end
    end

    logic [ROOT_W-1:0] root;
    vn_tag_t           tag_rt;

    vn_sqrt u_sqrt (
        .aclk     (aclk),
        .ld       (ld[P_DV-1:P_RT]),
        .sum_in   (sum_reg),
        .tag_in   (tag2_reg),
        .root_out (root),
        .tag_out  (tag_rt)
    );

    // divider lanes, one per component
    logic [QW-1:0] qx, qy, qz;

    vn_div_lane u_lane_x (
        .aclk (aclk), .ld (ld[P_OUT-1:P_DV]),
        .mag_in (tag_rt.ax), .len_in (root), .quo_out (qx)
    );
    vn_div_lane u_lane_y (
        .aclk (aclk), .ld (ld[P_OUT-1:P_DV]),
        .mag_in (tag_rt.ay), .len_in (root), .quo_out (qy)
    );
    vn_div_lane u_lane_z (
        .aclk (aclk), .ld (ld[P_OUT-1:P_DV]),
        .mag_in (tag_rt.az), .len_in (root), .quo_out (qz)
    );

    vn_side_t side_reg [DIV_STAGES];

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++) begin : g_side
            always_ff @(posedge aclk) begin
                if (ld[P_DV+g]) begin
                    if (g == 0) begin
                        side_reg[g].len  <= root;
                        side_reg[g].zero <= (root == '0);
                        side_reg[g].nx   <= tag_rt.nx;
                        side_reg[g].ny   <= tag_rt.ny;
                        side_reg[g].nz   <= tag_rt.nz;
                    end else begin
                        side_reg[g] <= side_reg[(g == 0) ? 0 : g-1];
                    end
                end
            end
        end
    endgenerate

    // merging stage: signs applied, zero vector forced to zero units
    vn_side_t         sd;
    logic [OUT_W-1:0] ux_next, uy_next, uz_next;
    logic [OUT_W-1:0] ux_reg, uy_reg, uz_reg, mag_reg;
    logic [QW-1:0]    qx_reg, qy_reg, qz_reg;
    logic             zero_reg;

    assign sd = side_reg[DIV_STAGES-1];

    always_comb begin
        ux_next = sd.nx ? (OUT_W'(0) - OUT_W'(qx)) : OUT_W'(qx);
        uy_next = sd.ny ? (OUT_W'(0) - OUT_W'(qy)) : OUT_W'(qy);
        uz_next = sd.nz ? (OUT_W'(0) - OUT_W'(qz)) : OUT_W'(qz);
        if (sd.zero) begin
            ux_next = '0;
            uy_next = '0;
            uz_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[P_OUT]) begin
            ux_reg   <= ux_next;
            uy_reg   <= uy_next;
            uz_reg   <= uz_next;
            mag_reg  <= OUT_W'(sd.len);
            zero_reg <= sd.zero;
            qx_reg   <= qx;
            qy_reg   <= qy;
            qz_reg   <= qz;
        end
    end

    assign m_tvalid = v_reg[P_OUT];
    assign m_tdata  = {mag_reg, uz_reg, uy_reg, ux_reg};
    assign m_tuser  = zero_reg;

    `VN_ASSERT_IMP(a_zero_out, m_tvalid && m_tuser,
        (m_tdata == '0), "zero vector with non-zero result")
    `VN_ASSERT_IMP(a_len_nonzero, m_tvalid && !m_tuser,
        (mag_reg != '0), "non-zero vector with zero length")
    `VN_ASSERT_IMP(a_unit_range, m_tvalid && !m_tuser,
        (qx_reg <= QW'(1 << FRAC_W)) && (qy_reg <= QW'(1 << FRAC_W))
        && (qz_reg <= QW'(1 << FRAC_W)), "unit component beyond one")
    `VN_ASSERT_NEXT(a_front_free, !v_reg[0] && s_tvalid && s_tready,
        v_reg[0], "accepted item lost at the input stage")

endmodule

[tb/sv/vec3_normalize_checker.sv]
// checker for the vector normalize block: predicts length and unit vector
// of each accepted item and compares with the result channel; no dependencies
`timescale 1ns / 100ps

module vec3_normalize_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tuser,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);

    typedef struct packed {
        logic        zero_length;
        logic [15:0] magnitude;
        logic [15:0] unit_z;
        logic [15:0] unit_y;
        logic [15:0] unit_x;
    } norm_result_t;

    norm_result_t expected_norms[$];

    function automatic logic [31:0] floor_sqrt(input logic [63:0] n);
        logic [31:0] root;
        logic [63:0] trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = {32'b0, root | (32'd1 << b)};
            if (trial * trial <= n)
                root = root | (32'd1 << b);
        end
        return root;
    endfunction

    function automatic logic [15:0] scale_component(input logic [16:0] mag, input logic neg,
                                                    input logic [31:0] len);
        logic [63:0] q;
        q = (({47'b0, mag} << 14) + {32'b0, len >> 1}) / {32'b0, len};
        if (neg)
            q = 64'd0 - q;
        return q[15:0];
    endfunction

    function automatic norm_result_t normalize_vector(input logic [47:0] v);
        norm_result_t r;
        logic [16:0] a [3];
        logic        n [3];
        logic [63:0] sum;
        logic [31:0] len;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            n[i] = v[16*i+15];
            a[i] = n[i] ? 17'(-$signed({v[16*i+15], v[16*i +: 16]})) : {1'b0, v[16*i +: 16]};
            sum  = sum + {47'b0, a[i]} * {47'b0, a[i]};
        end
        len = floor_sqrt(sum);
        r = '0;
        if (len == 0) begin
            r.zero_length = 1'b1;
        end else begin
            r.unit_x    = scale_component(a[0], n[0], len);
            r.unit_y    = scale_component(a[1], n[1], len);
            r.unit_z    = scale_component(a[2], n[2], len);
            r.magnitude = len[15:0];
        end
        return r;
    endfunction

    assign pending_count = expected_norms.size();

    always @(posedge aclk) begin
        norm_result_t want;
        norm_result_t got;
        if (!aresetn) begin
            fail_count   <= 0;
            result_count <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_norms.push_back(normalize_vector(s_tdata));
            if (m_tvalid && m_tready) begin
                result_count <= result_count + 1;
                got = {m_tuser, m_tdata[63:48], m_tdata[47:32], m_tdata[31:16], m_tdata[15:0]};
                if (expected_norms.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_norms.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display("mismatch: expected x=%h y=%h z=%h len=%h zero=%b, got x=%h y=%h z=%h len=%h zero=%b",
                                     want.unit_x, want.unit_y, want.unit_z, want.magnitude,
                                     want.zero_length, got.unit_x, got.unit_y, got.unit_z,
                                     got.magnitude, got.zero_length);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[tb/sv/vec3_normalize_top_test.sv]
// stimulus and verdict for the vector normalize block
// depends on vec3_normalize_top and vec3_normalize_checker
`timescale 1ns / 100ps

module vec3_normalize_top_test;

    localparam int RANDOM_VECTORS = 1030;
    localparam int IDLE_LIMIT     = 5000;
    localparam int DRAIN_CYCLES   = 60;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // in_x, in_y, in_z
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // unit_x, unit_y, unit_z, magnitude
    logic        m_tuser;   // zero_length

    int fail_count;
    int pending_count;
    int result_count;
    int idle_cycles;
    int sent_count;
    int stall_mode;

    vec3_normalize_top dut (.*);

    vec3_normalize_checker norm_check (.*);

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // receiver stall pattern: none, occasional random, or frequent random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_mode <= 0;
        end else begin
            if ($urandom_range(0, 199) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 7) < 3);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_count);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [15:0] random_component();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 3)) - 16'd1;
            3: return 16'($urandom_range(0, 255)) - 16'd128;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_vector(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    task automatic pause_sender();
        int gap;
        gap = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    initial begin
        logic [15:0] c [3];
        int burst;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        sent_count = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero vector, extremes, single-axis and 2D cases, ties and tiny lengths
        send_vector(16'h0000, 16'h0000, 16'h0000);
        send_vector(16'h8000, 16'h8000, 16'h8000);
        send_vector(16'h7fff, 16'h7fff, 16'h7fff);
        send_vector(16'h8000, 16'h0000, 16'h0000);
        send_vector(16'h0000, 16'h7fff, 16'h0000);
        send_vector(16'h0000, 16'h0000, 16'h8000);
        send_vector(16'h0001, 16'h0000, 16'h0000);
        send_vector(16'hffff, 16'h0000, 16'h0000);
        send_vector(16'h0001, 16'h0001, 16'h0001);
        send_vector(16'hffff, 16'hffff, 16'hffff);
        send_vector(16'h0003, 16'h0004, 16'h0000);
        send_vector(16'hfffd, 16'h0004, 16'h0000);
        send_vector(16'h0100, 16'hff00, 16'h0000);
        send_vector(16'h7fff, 16'h8000, 16'h0001);
        send_vector(16'h0001, 16'h0002, 16'h0002);
        send_vector(16'h5555, 16'haaaa, 16'h0000);
        send_vector(16'h0000, 16'h0001, 16'h8000);
        send_vector(16'h8000, 16'h7fff, 16'h0000);

        while (sent_count < 18 + RANDOM_VECTORS) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                for (int i = 0; i < 3; i++)
                    c[i] = random_component();
                if ($urandom_range(0, 9) == 0)
                    c[2] = 16'h0000;
                send_vector(c[0], c[1], c[2]);
            end
            pause_sender();
        end
        s_tvalid <= 1'b0;

        while (pending_count != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d vectors (directed extremes, zero and 2D cases, then random)",
                 sent_count);
        $display("checked %0d results under random sender gaps and receiver stalls",
                 result_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
